@@ rtl/core/lfps_pkg.sv @@
`timescale 1ns / 1ps
// shared types, widths and constants of the line-follow pid steering block
package lfps_pkg;

  localparam int unsigned PosW    = 16;
  localparam int unsigned BaseW   = 10;
  localparam int unsigned CorrW   = 13;
  localparam int unsigned SpeedW  = 10;
  localparam int unsigned GainW   = 16;
  localparam int unsigned LimitW  = 12;
  localparam int unsigned ErrW    = 18;
  localparam int unsigned IntW    = 14;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  localparam logic [PosW-1:0]   LostMark = 16'hFFFF;
  localparam logic [SpeedW-1:0] SpeedMax = 10'd999;

  localparam logic [CfgIdxW-1:0] CfgKp     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKi     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKd     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLimit  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTarget = 3'd4;

  typedef enum logic {
    OpSample = 1'b0,
    OpClear  = 1'b1
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [PosW-1:0]  sensor_pos;
    logic [BaseW-1:0] nominal_speed;
  } item_t;

  typedef struct packed {
    logic signed [CorrW-1:0] correction;
    logic [SpeedW-1:0]       left_drive;
    logic [SpeedW-1:0]       right_drive;
    logic                    line_lost;
  } result_t;

  typedef struct packed {
    logic signed [GainW-1:0] kp_gain;
    logic signed [GainW-1:0] ki_gain;
    logic signed [GainW-1:0] kd_gain;
    logic [LimitW-1:0]       output_limit;
    logic [PosW-1:0]         target_position;
  } cfg_t;

  typedef struct packed {
    logic signed [IntW-1:0] integral_sum;
    logic signed [ErrW-1:0] previous_error;
  } state_t;

endpackage

@@ rtl/core/line_follow_pid_steering.sv @@
`timescale 1ns / 1ps
// Line-follow PID steering controller. One beat carries a line position and a base speed;
// the result beat with the steering correction and both wheel speeds is loaded into the result
// register as the beat leaves its input register, which holds the beat while the output stalls, and
// the block takes a new beat every cycle while the output is drained.
// The whole PID step (integral clamp, three gain products, shift and limit, wheel mixing) is
// one combinational pass between the input register and the result register, so the integral
// and last error are updated as each beat moves to the output. A clear beat resets that state
// and gives no result. Position 0xFFFF marks a lost line: the state is held and the correction
// is a quarter of the output limit, signed after the last error. The user must write configuration
// only while the block is idle; the block itself does not enforce it.
module line_follow_pid_steering #(
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lfps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lfps_pkg::CfgDatW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lfps_pkg::item_t               in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lfps_pkg::result_t             out_result_o
);

  lfps_pkg::cfg_t    cfg;
  lfps_pkg::state_t  state_q, state_d;
  lfps_pkg::item_t   item_q;
  lfps_pkg::result_t res_q, res_d;
  logic              in_vld_q, in_vld_d;
  logic              out_vld_q, out_vld_d;
  logic              accept, advance;

  lfps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lfps_pid_law #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_law (
    .item_i   (item_q),
    .cfg_i    (cfg),
    .state_i  (state_q),
    .result_o (res_d),
    .state_o  (state_d)
  );

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = (item_q.op == lfps_pkg::OpSample);
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_result_o = res_q;

endmodule

@@ rtl/core/lfps_cfg_regs.sv @@
`timescale 1ns / 1ps
// configuration register file for gains, limit and target
module lfps_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lfps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lfps_pkg::CfgDatW-1:0]  cfg_data_i,
  output lfps_pkg::cfg_t                cfg_o
);

  lfps_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lfps_pkg::CfgKp:     cfg_d.kp_gain = $signed(cfg_data_i);
        lfps_pkg::CfgKi:     cfg_d.ki_gain = $signed(cfg_data_i);
        lfps_pkg::CfgKd:     cfg_d.kd_gain = $signed(cfg_data_i);
        lfps_pkg::CfgLimit:  cfg_d.output_limit = cfg_data_i[lfps_pkg::LimitW-1:0];
        lfps_pkg::CfgTarget: cfg_d.target_position = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/lfps_pid_law.sv @@
`timescale 1ns / 1ps
// single-pass pid step, lost-line fallback and wheel speed mixing
module lfps_pid_law #(
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  lfps_pkg::item_t   item_i,
  input  lfps_pkg::cfg_t    cfg_i,
  input  lfps_pkg::state_t  state_i,
  output lfps_pkg::result_t result_o,
  output lfps_pkg::state_t  state_o
);

  localparam int unsigned AccW   = lfps_pkg::ErrW + 1;
  localparam int unsigned PkW    = lfps_pkg::GainW + lfps_pkg::ErrW;
  localparam int unsigned PiW    = lfps_pkg::GainW + lfps_pkg::IntW;
  localparam int unsigned PdW    = lfps_pkg::GainW + AccW;
  localparam int unsigned SumW   = PdW + 2;
  localparam int unsigned RaiseW = lfps_pkg::LimitW + 1;

  logic                              lost;
  logic signed [lfps_pkg::ErrW-1:0]  err;
  logic [lfps_pkg::IntW-1:0]         ilim;
  logic signed [AccW-1:0]            ilim_pos, ilim_neg;
  logic signed [AccW-1:0]            int_acc;
  logic signed [lfps_pkg::IntW-1:0]  int_new;
  logic signed [AccW-1:0]            deriv;
  logic signed [PkW-1:0]             p_kp;
  logic signed [PiW-1:0]             p_ki;
  logic signed [PdW-1:0]             p_kd;
  logic signed [SumW-1:0]            sum;
  logic [SumW-1:0]                   mag, mag_sh;
  logic [lfps_pkg::LimitW-1:0]       pid_mag, lost_mag, corr_mag;
  logic                              corr_neg;
  logic signed [lfps_pkg::CorrW-1:0] corr;
  logic                              prev_pos;
  logic [RaiseW-1:0]                 raised;
  logic [lfps_pkg::SpeedW-1:0]       base_cl, raised_cl;

  assign lost = (item_i.sensor_pos == lfps_pkg::LostMark);
  assign err  = $signed({2'b00, cfg_i.target_position})
              - $signed({2'b00, item_i.sensor_pos});

  // integral limit is twice the output limit
  assign ilim     = {1'b0, cfg_i.output_limit, 1'b0};
  assign ilim_pos = $signed({{(AccW-lfps_pkg::IntW){1'b0}}, ilim});
  assign ilim_neg = -ilim_pos;
  assign int_acc  = AccW'(state_i.integral_sum) + AccW'(err);

  always_comb begin
    if (int_acc > ilim_pos) begin
      int_new = ilim_pos[lfps_pkg::IntW-1:0];
    end else if (int_acc < ilim_neg) begin
      int_new = ilim_neg[lfps_pkg::IntW-1:0];
    end else begin
      int_new = int_acc[lfps_pkg::IntW-1:0];
    end
  end

  assign deriv = AccW'(err) - AccW'(state_i.previous_error);

  assign p_kp = cfg_i.kp_gain * err;
  assign p_ki = cfg_i.ki_gain * int_new;
  assign p_kd = cfg_i.kd_gain * deriv;
  assign sum  = SumW'(p_kp) + SumW'(p_ki) + SumW'(p_kd);

  // truncation toward zero on the magnitude
  assign mag    = sum[SumW-1] ? $unsigned(-sum) : $unsigned(sum);
  assign mag_sh = mag >> GAIN_FRAC_BITS;
  assign pid_mag = (mag_sh > SumW'(cfg_i.output_limit)) ? cfg_i.output_limit
                                                       : mag_sh[lfps_pkg::LimitW-1:0];

  assign prev_pos = !state_i.previous_error[lfps_pkg::ErrW-1] && (|state_i.previous_error);
  assign lost_mag = cfg_i.output_limit >> 2;

  assign corr_mag = lost ? lost_mag : pid_mag;
  assign corr_neg = lost ? !prev_pos : sum[SumW-1];
  assign corr     = corr_neg ? -$signed({1'b0, corr_mag}) : $signed({1'b0, corr_mag});

  // mixing: the raised wheel gets base plus correction magnitude
  assign raised    = RaiseW'(item_i.nominal_speed) + RaiseW'(corr_mag);
  assign raised_cl = (raised > RaiseW'(lfps_pkg::SpeedMax)) ? lfps_pkg::SpeedMax
                                                            : raised[lfps_pkg::SpeedW-1:0];
  assign base_cl   = (item_i.nominal_speed > lfps_pkg::SpeedMax) ? lfps_pkg::SpeedMax
                                                                 : item_i.nominal_speed;

  always_comb begin
    result_o.correction = corr;
    result_o.line_lost  = lost;
    if (!corr[lfps_pkg::CorrW-1] && (|corr)) begin
      result_o.left_drive  = raised_cl;
      result_o.right_drive = base_cl;
    end else begin
      result_o.left_drive  = base_cl;
      result_o.right_drive = raised_cl;
    end
  end

  always_comb begin
    state_o = state_i;
    if (item_i.op == lfps_pkg::OpClear) begin
      state_o = '0;
    end else if (!lost) begin
      state_o.integral_sum   = int_new;
      state_o.previous_error = err;
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the line-follow pid steering block
module tb;

  localparam logic [lfps_pkg::CfgIdxW-1:0] CfgUnused = 3'd5;
  localparam int FracBits = 8;
  localparam int SettleCycles = 8;
  localparam int HoldCycles = 80;
  localparam int NumDirected = 37;
  localparam int NumPhases = 10;
  localparam int BeatsPerPhase = 175;

  typedef enum logic {
    RowBeat,
    RowCfg
  } row_kind_e;

  typedef struct {
    row_kind_e                        kind;
    logic [lfps_pkg::CfgIdxW-1:0]     idx;
    logic [lfps_pkg::CfgDatW-1:0]     data;
    lfps_pkg::item_t                  item;
    bit                               known;
    lfps_pkg::result_t                res;
  } row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [lfps_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [lfps_pkg::CfgDatW-1:0]  cfg_data_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  lfps_pkg::item_t               in_item_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  lfps_pkg::result_t             out_result_o;

  int kp_q, ki_q, kd_q, lim_q, tgt_q;
  int integ_q, prev_err_q;
  lfps_pkg::result_t steer_expect_q[$];
  int mismatches;
  bit calm;
  bit hold_req;
  row_t dir_tbl [NumDirected];

  line_follow_pid_steering #(
    .GAIN_FRAC_BITS(FracBits)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_result_o(out_result_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int clamp_int(int v, int lo, int hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic bit steer_predict(input lfps_pkg::item_t it,
                                       output lfps_pkg::result_t r);
    int err, ilim, deriv, corr, left, right, base;
    longint sum, mag;
    bit lost;
    r = '0;
    if (it.op == lfps_pkg::OpClear) begin
      integ_q = 0;
      prev_err_q = 0;
      return 1'b0;
    end
    base = int'(it.nominal_speed);
    lost = (it.sensor_pos == lfps_pkg::LostMark);
    if (lost) begin
      corr = (prev_err_q > 0) ? lim_q / 4 : -(lim_q / 4);
    end else begin
      err = tgt_q - int'(it.sensor_pos);
      ilim = lim_q * 2;
      integ_q = clamp_int(integ_q + err, -ilim, ilim);
      deriv = err - prev_err_q;
      prev_err_q = err;
      sum = longint'(kp_q) * err + longint'(ki_q) * integ_q + longint'(kd_q) * deriv;
      mag = (sum < 0) ? -sum : sum;
      mag = mag >> FracBits;
      if (mag > lim_q) mag = lim_q;
      corr = (sum < 0) ? -int'(mag) : int'(mag);
    end
    left = base;
    right = base;
    if (corr > 0) left = base + corr;
    else right = base - corr;
    left = clamp_int(left, 0, int'(lfps_pkg::SpeedMax));
    right = clamp_int(right, 0, int'(lfps_pkg::SpeedMax));
    r.correction = corr[lfps_pkg::CorrW-1:0];
    r.left_drive = left[lfps_pkg::SpeedW-1:0];
    r.right_drive = right[lfps_pkg::SpeedW-1:0];
    r.line_lost = lost;
    return 1'b1;
  endfunction

  function automatic row_t cfg_row(logic [lfps_pkg::CfgIdxW-1:0] idx,
                                   logic [lfps_pkg::CfgDatW-1:0] data);
    row_t r;
    r.kind = RowCfg;
    r.idx = idx;
    r.data = data;
    r.item = '0;
    r.known = 1'b0;
    r.res = '0;
    return r;
  endfunction

  function automatic row_t beat_row(lfps_pkg::op_e op, logic [lfps_pkg::PosW-1:0] pos,
                                    logic [lfps_pkg::BaseW-1:0] base);
    row_t r;
    r.kind = RowBeat;
    r.idx = '0;
    r.data = '0;
    r.item.op = op;
    r.item.sensor_pos = pos;
    r.item.nominal_speed = base;
    r.known = 1'b0;
    r.res = '0;
    return r;
  endfunction

  function automatic row_t known_row(logic [lfps_pkg::PosW-1:0] pos,
                                     logic [lfps_pkg::BaseW-1:0] base, int corr,
                                     int left, int right, bit lost);
    row_t r;
    r = beat_row(lfps_pkg::OpSample, pos, base);
    r.known = 1'b1;
    r.res.correction = corr[lfps_pkg::CorrW-1:0];
    r.res.left_drive = left[lfps_pkg::SpeedW-1:0];
    r.res.right_drive = right[lfps_pkg::SpeedW-1:0];
    r.res.line_lost = lost;
    return r;
  endfunction

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [lfps_pkg::CfgDatW-1:0] rand_gain();
    case ($urandom_range(0, 4))
      0: begin
        case ($urandom_range(0, 2))
          0: return 16'h7FFF;
          1: return 16'h8000;
          default: return 16'h0000;
        endcase
      end
      1, 2: return 16'(int'($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic lfps_pkg::item_t rand_item();
    lfps_pkg::item_t it;
    int r, span, off;
    r = $urandom_range(0, 99);
    it.op = (r < 4) ? lfps_pkg::OpClear : lfps_pkg::OpSample;
    it.nominal_speed = ($urandom_range(0, 9) == 0) ? lfps_pkg::BaseW'($urandom)
                                                   : lfps_pkg::BaseW'($urandom_range(0, 999));
    if (r < 14) begin
      it.sensor_pos = lfps_pkg::LostMark;
    end else if (r < 24) begin
      it.sensor_pos = lfps_pkg::PosW'($urandom);
    end else if (r < 28) begin
      it.sensor_pos = $urandom_range(0, 1) ? 16'd0 : 16'd65534;
    end else begin
      span = 1 << $urandom_range(0, 12);
      off = int'($urandom_range(0, 2 * span)) - span;
      it.sensor_pos = lfps_pkg::PosW'(clamp_int(tgt_q + off, 0, 65534));
    end
    return it;
  endfunction

  task automatic cfg_write(input logic [lfps_pkg::CfgIdxW-1:0] idx,
                           input logic [lfps_pkg::CfgDatW-1:0] data);
    in_valid_i <= 1'b0;
    while (steer_expect_q.size() != 0) @(posedge clk_i);
    // clear beats leave no result, so give the pipeline time to empty
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      lfps_pkg::CfgKp: kp_q = int'($signed(data));
      lfps_pkg::CfgKi: ki_q = int'($signed(data));
      lfps_pkg::CfgKd: kd_q = int'($signed(data));
      lfps_pkg::CfgLimit: lim_q = int'(data[lfps_pkg::LimitW-1:0]);
      lfps_pkg::CfgTarget: tgt_q = int'(data);
      default: ;
    endcase
  endtask

  task automatic send_beat(input lfps_pkg::item_t it, input bit known,
                           input lfps_pkg::result_t known_res);
    int gap;
    bit has;
    lfps_pkg::result_t r;
    gap = calm ? 0 : pause_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    has = steer_predict(it, r);
    if (has) steer_expect_q.push_back(known ? known_res : r);
  endtask

  task automatic rand_config();
    cfg_write(lfps_pkg::CfgKp, rand_gain());
    cfg_write(lfps_pkg::CfgKi, rand_gain());
    cfg_write(lfps_pkg::CfgKd, rand_gain());
    case ($urandom_range(0, 5))
      0: cfg_write(lfps_pkg::CfgLimit, 16'd0);
      1: cfg_write(lfps_pkg::CfgLimit, 16'd4095);
      2: cfg_write(lfps_pkg::CfgLimit, lfps_pkg::CfgDatW'($urandom_range(1, 63)));
      default: cfg_write(lfps_pkg::CfgLimit, lfps_pkg::CfgDatW'($urandom_range(0, 4095)));
    endcase
    case ($urandom_range(0, 7))
      0: cfg_write(lfps_pkg::CfgTarget, 16'd0);
      1: cfg_write(lfps_pkg::CfgTarget, 16'd65534);
      2: cfg_write(lfps_pkg::CfgTarget, 16'hFFFF);
      default: cfg_write(lfps_pkg::CfgTarget, lfps_pkg::CfgDatW'($urandom_range(0, 65534)));
    endcase
  endtask

  // result checker
  always @(posedge clk_i) begin : check_blk
    lfps_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (steer_expect_q.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        want = steer_expect_q.pop_front();
        if (out_result_o.correction !== want.correction) begin
          $error("correction: expected %0d, actual %0d", want.correction,
                 out_result_o.correction);
          mismatches++;
        end
        if (out_result_o.left_drive !== want.left_drive) begin
          $error("left_drive: expected %0d, actual %0d", want.left_drive,
                 out_result_o.left_drive);
          mismatches++;
        end
        if (out_result_o.right_drive !== want.right_drive) begin
          $error("right_drive: expected %0d, actual %0d", want.right_drive,
                 out_result_o.right_drive);
          mismatches++;
        end
        if (out_result_o.line_lost !== want.line_lost) begin
          $error("line_lost: expected %0d, actual %0d", want.line_lost,
                 out_result_o.line_lost);
          mismatches++;
        end
      end
    end
  end

  // output side back-pressure
  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (calm) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 35);
        repeat (1 + pause_len()) @(posedge clk_i);
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("tb failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    mismatches = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    kp_q = 0;
    ki_q = 0;
    kd_q = 0;
    lim_q = 0;
    tgt_q = 0;
    integ_q = 0;
    prev_err_q = 0;

    dir_tbl = '{
      known_row(16'd100, 10'd500, 0, 500, 500, 1'b0),
      known_row(16'd0, 10'd1023, 0, 999, 999, 1'b0),
      known_row(lfps_pkg::LostMark, 10'd0, 0, 0, 0, 1'b1),
      beat_row(lfps_pkg::OpClear, 16'hFFFF, 10'h3FF),
      known_row(16'd65534, 10'd999, 0, 999, 999, 1'b0),
      cfg_row(lfps_pkg::CfgLimit, 16'd4095),
      known_row(lfps_pkg::LostMark, 10'd500, -1023, 500, 999, 1'b1),
      cfg_row(lfps_pkg::CfgKp, 16'h0100),
      cfg_row(lfps_pkg::CfgTarget, 16'h8000),
      beat_row(lfps_pkg::OpSample, 16'h8000, 10'd500),
      beat_row(lfps_pkg::OpSample, 16'h0000, 10'd500),
      beat_row(lfps_pkg::OpSample, 16'hFFFE, 10'd0),
      beat_row(lfps_pkg::OpSample, lfps_pkg::LostMark, 10'd300),
      cfg_row(lfps_pkg::CfgKp, 16'h7FFF),
      cfg_row(lfps_pkg::CfgKi, 16'h7FFF),
      cfg_row(lfps_pkg::CfgKd, 16'h8000),
      beat_row(lfps_pkg::OpSample, 16'h0000, 10'h3FF),
      beat_row(lfps_pkg::OpSample, 16'hFFFE, 10'd512),
      beat_row(lfps_pkg::OpClear, 16'h1234, 10'd0),
      beat_row(lfps_pkg::OpSample, lfps_pkg::LostMark, 10'd100),
      cfg_row(lfps_pkg::CfgTarget, 16'hFFFF),
      cfg_row(lfps_pkg::CfgKi, 16'h8000),
      cfg_row(lfps_pkg::CfgLimit, 16'd1),
      beat_row(lfps_pkg::OpSample, 16'h0000, 10'd998),
      beat_row(lfps_pkg::OpSample, 16'hFFFE, 10'd1),
      cfg_row(lfps_pkg::CfgLimit, 16'd0),
      beat_row(lfps_pkg::OpSample, 16'd1000, 10'd700),
      beat_row(lfps_pkg::OpSample, lfps_pkg::LostMark, 10'd700),
      cfg_row(CfgUnused, 16'hFFFF),
      cfg_row(lfps_pkg::CfgLimit, 16'd4095),
      cfg_row(lfps_pkg::CfgTarget, 16'd0),
      cfg_row(lfps_pkg::CfgKp, 16'h0001),
      cfg_row(lfps_pkg::CfgKi, 16'h0001),
      cfg_row(lfps_pkg::CfgKd, 16'h0001),
      beat_row(lfps_pkg::OpSample, 16'hAAAA, 10'h2AA),
      beat_row(lfps_pkg::OpSample, 16'h5555, 10'h155),
      beat_row(lfps_pkg::OpSample, 16'h0001, 10'd0)
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == RowCfg) cfg_write(dir_tbl[i].idx, dir_tbl[i].data);
      else send_beat(dir_tbl[i].item, dir_tbl[i].known, dir_tbl[i].res);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      rand_config();
      calm = (ph == 2 || ph == 4 || ph == 7);
      // long output hold while the input keeps offering beats
      if (ph == 4) hold_req = 1'b1;
      repeat (BeatsPerPhase) send_beat(rand_item(), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (steer_expect_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
